FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define CCMP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define CCMP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ccmp_pkg.sv
// Types, coefficients and angle table of the calibrated compass heading block.
`timescale 1ns / 1ps
`default_nettype none
package ccmp_pkg;

	localparam int VW = 25;
	localparam int CW = 45;
	localparam int AW = 25;
	localparam int MID_AW = 4;
	localparam int MAX_STEPS = 24;
	localparam int NORM_MSB = 40;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
	} cal_t;

	localparam logic signed [17:0] MAT1 [0:2][0:2] = '{
		'{ 18'sd31431,  18'sd2241,  -18'sd6076},
		'{ 18'sd2241,   18'sd38324, -18'sd1540},
		'{-18'sd6076,  -18'sd1540,   18'sd32596}
	};
	localparam logic signed [29:0] OFF1 [0:2] = '{30'sd5566237, -30'sd1502416, 30'sd4814605};

	localparam logic signed [22:0] MAT2 [0:1][0:2] = '{
		'{ 23'sd1235086, -23'sd39397,   23'sd204957},
		'{-23'sd39397,    23'sd1015048, -23'sd75652}
	};
	localparam logic signed [25:0] OFF2 [0:2] = '{26'sd28758, 26'sd11831, 26'sd8559};

	localparam logic [20:0] ATAN_TAB [0:MAX_STEPS-1] = '{
		21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
		21'd22916, 21'd11459, 21'd5730, 21'd2865, 21'd1432, 21'd716,
		21'd358, 21'd179, 21'd90, 21'd45, 21'd22, 21'd11,
		21'd6, 21'd3, 21'd1, 21'd1, 21'd0, 21'd0
	};

	localparam logic signed [AW-1:0] HALF_TURN = 25'sd4608000;
	localparam logic signed [17:0] HEAD_MAX = 18'sd18000;

endpackage
`default_nettype wire

FILE: hdl/calibrated_compass_heading.sv
// Top level of the calibrated compass heading block.
// Path: an accepted item passes through six correction stages, a queue write, three fold
// and normalisation stages, one stage per CORDIC step, one rounding stage and a final
// queue write; the accepting edge loads the first correction stage.
// Throughput: one item per cycle while full is low and the back end holds output credit,
// set by the fully pipelined correction and CORDIC stages.
// Reset: arst_n clears both queues, the credit counters and all stage valid bits at once.
`timescale 1ns / 1ps
`default_nettype none
module calibrated_compass_heading #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] mag_x,
	input  wire logic signed [15:0] mag_y,
	input  wire logic signed [15:0] mag_z,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [15:0]      heading
);
	import ccmp_pkg::*;

	localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int OUT_AW = $clog2(N + 8);

	logic  fr_valid;
	cal_t  fr_res;
	cal_t  mid_data;
	logic  mid_empty;
	logic  mid_take;
	logic  bk_valid;
	logic signed [15:0] bk_head;
	logic [15:0] out_data;
	logic  out_pop;

	assign out_pop = pop && !empty;

	ccmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.mag_z     (mag_z),
		.credit    (mid_take),
		.res_valid (fr_valid),
		.res       (fr_res)
	);

	ccmp_fifo #(.AW(MID_AW), .W($bits(cal_t))) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_valid),
		.wdata  (fr_res),
		.pop    (mid_take),
		.rdata  (mid_data),
		.empty  (mid_empty)
	);

	ccmp_back #(.CORDIC_STEPS(CORDIC_STEPS), .CAP(2**OUT_AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_empty (mid_empty),
		.src       (mid_data),
		.take      (mid_take),
		.credit    (out_pop),
		.res_valid (bk_valid),
		.heading   (bk_head)
	);

	ccmp_fifo #(.AW(OUT_AW), .W(16)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_valid),
		.wdata  (bk_head),
		.pop    (pop),
		.rdata  (out_data),
		.empty  (empty)
	);

	assign heading = $signed(out_data);
endmodule
`default_nettype wire

FILE: hdl/ccmp_fifo.sv
// Small register-file queue with occupancy count.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_fifo #(
	parameter int AW = 4,
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	logic [W-1:0] mem [0:(2**AW)-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_pop;

	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/ccmp_front.sv
// Front end: item intake and the two hard- and soft-iron correction stages.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] mag_x,
	input  wire logic signed [15:0] mag_y,
	input  wire logic signed [15:0] mag_z,
	input  wire logic               credit,
	output logic                    res_valid,
	output ccmp_pkg::cal_t          res
);
	import ccmp_pkg::*;

	localparam int CAP = 2**MID_AW;

	logic [MID_AW:0]       occ_q;
	logic                  accept;
	logic [6:1]            vld_q;
	logic signed [29:0]    d1_s1 [0:2];
	logic signed [47:0]    p1_s2 [0:2][0:2];
	logic signed [VW-1:0]  v1_s3 [0:2];
	logic signed [25:0]    d2_s4 [0:2];
	logic signed [47:0]    p2_s5 [0:1][0:2];
	logic signed [49:0]    sum1   [0:2];
	logic signed [49:0]    sum2   [0:1];
	logic signed [29:0]    raw    [0:2];

	assign full   = (occ_q == (MID_AW+1)'(CAP));
	assign accept = push && !full;

	assign raw[0] = {{2{mag_x[15]}}, mag_x, 12'b0};
	assign raw[1] = {{2{mag_y[15]}}, mag_y, 12'b0};
	assign raw[2] = {{2{mag_z[15]}}, mag_z, 12'b0};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum1[r] = 50'(p1_s2[r][0]) + 50'(p1_s2[r][1]) + 50'(p1_s2[r][2]) + 50'sd524288;
		end
		for (int r = 0; r < 2; r++) begin
			sum2[r] = 50'(p2_s5[r][0]) + 50'(p2_s5[r][1]) + 50'(p2_s5[r][2]) + 50'sd524288;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			d1_s1[c] <= raw[c] - OFF1[c];
			v1_s3[c] <= sum1[c][44:20];
			d2_s4[c] <= {v1_s3[c][VW-1], v1_s3[c]} - OFF2[c];
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				p1_s2[r][c] <= d1_s1[c] * MAT1[r][c];
			end
		end
		for (int r = 0; r < 2; r++) begin
			for (int c = 0; c < 3; c++) begin
				p2_s5[r][c] <= d2_s4[c] * MAT2[r][c];
			end
		end
		res.x <= sum2[0][44:20];
		res.y <= sum2[1][44:20];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			occ_q <= '0;
		end else begin
			vld_q <= {vld_q[5:1], accept};
			if (accept && !credit) begin
				occ_q <= occ_q + 1'b1;
			end else if (!accept && credit) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	assign res_valid = vld_q[6];
endmodule
`default_nettype wire

FILE: hdl/ccmp_back.sv
// Back end: quadrant fold, normalisation, the pipelined CORDIC and the rounded, clamped heading.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_back #(
	parameter int CORDIC_STEPS = 16,
	parameter int CAP = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_empty,
	input  wire ccmp_pkg::cal_t     src,
	output logic                    take,
	input  wire logic               credit,
	output logic                    res_valid,
	output logic signed [15:0]      heading
);
	import ccmp_pkg::*;

	localparam int N = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
	localparam int OW = $clog2(CAP + 1);

	logic [OW-1:0]          occ_q;
	logic [N+4:1]           vld_q;
	logic signed [25:0]     a_s1, b_s1;
	logic signed [AW-1:0]   ang_s1, ang_s2;
	logic [VW-1:0]          ma_s1;
	logic                   zero_s1, zero_s2;
	logic signed [25:0]     a_s2, b_s2;
	logic [5:0]             sh_s2;
	logic signed [CW-1:0]   rot_a_s [0:N];
	logic signed [CW-1:0]   rot_b_s [0:N];
	logic signed [AW-1:0]   rot_ang_s [0:N];
	logic                   rot_zero_s [0:N];
	logic signed [25:0]     ya, xb, na, nb;
	logic [VW-1:0]          abs_a, abs_b;
	logic [5:0]             msb;
	logic signed [25:0]     rnd;
	logic signed [17:0]     quot;
	logic signed [15:0]     head_c;

	assign take = !src_empty && (occ_q != OW'(CAP));

	always_comb begin
		ya = {src.y[VW-1], src.y};
		xb = {src.x[VW-1], src.x};
		na = (ya < 0) ? -ya : ya;
		nb = (ya < 0) ? -xb : xb;
		abs_a = na[VW-1:0];
		abs_b = (nb < 0) ? VW'(-nb) : nb[VW-1:0];
	end

	always_comb begin
		msb = '0;
		for (int i = 0; i < VW; i++) begin
			if (ma_s1[i]) begin
				msb = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= na;
		b_s1    <= nb;
		zero_s1 <= (src.x == '0) && (src.y == '0);
		ma_s1   <= (abs_b > abs_a) ? abs_b : abs_a;
		if (ya < 0) begin
			ang_s1 <= (xb >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			ang_s1 <= '0;
		end
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		ang_s2  <= ang_s1;
		zero_s2 <= zero_s1;
		sh_s2   <= 6'(NORM_MSB) - msb;
		rot_a_s[0]    <= CW'(a_s2) <<< sh_s2;
		rot_b_s[0]    <= CW'(b_s2) <<< sh_s2;
		rot_ang_s[0]  <= ang_s2;
		rot_zero_s[0] <= zero_s2;
	end

	for (genvar gi = 0; gi < N; gi++) begin : g_rot
		always_ff @(posedge clk) begin
			rot_zero_s[gi+1] <= rot_zero_s[gi];
			if (rot_b_s[gi] > 0) begin
				rot_a_s[gi+1]   <= rot_a_s[gi] + (rot_b_s[gi] >>> gi);
				rot_b_s[gi+1]   <= rot_b_s[gi] - (rot_a_s[gi] >>> gi);
				rot_ang_s[gi+1] <= rot_ang_s[gi] + $signed({4'b0, ATAN_TAB[gi]});
			end else begin
				rot_a_s[gi+1]   <= rot_a_s[gi] - (rot_b_s[gi] >>> gi);
				rot_b_s[gi+1]   <= rot_b_s[gi] + (rot_a_s[gi] >>> gi);
				rot_ang_s[gi+1] <= rot_ang_s[gi] - $signed({4'b0, ATAN_TAB[gi]});
			end
		end
	end

	always_comb begin
		rnd  = {rot_ang_s[N][AW-1], rot_ang_s[N]} + 26'sd128;
		quot = rnd[25:8];
		if (rot_zero_s[N]) begin
			head_c = '0;
		end else if (quot > HEAD_MAX) begin
			head_c = HEAD_MAX[15:0];
		end else if (quot < -HEAD_MAX) begin
			head_c = 16'(-HEAD_MAX);
		end else begin
			head_c = quot[15:0];
		end
	end

	always_ff @(posedge clk) begin
		heading <= head_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			occ_q <= '0;
		end else begin
			vld_q <= {vld_q[N+3:1], take};
			if (take && !credit) begin
				occ_q <= occ_q + 1'b1;
			end else if (!take && credit) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	assign res_valid = vld_q[N+4];
endmodule
`default_nettype wire

FILE: hdl/ccmp_checker.sv
// Port-level checker for the calibrated compass heading block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ccmp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [15:0] heading
);
	logic head_ok;
	logic hold_req;

	assign head_ok  = (heading >= -16'sd18000) && (heading <= 16'sd18000);
	assign hold_req = !empty && !pop;

	`CCMP_ASSERT(a_head_range, clk, arst_n, !empty |-> head_ok, "heading out of range")
	`CCMP_ASSERT(a_head_hold, clk, arst_n, hold_req |=> (!empty && $stable(heading)), "waiting item changed")
	`CCMP_ASSERT_ALWAYS(a_reset_clear, clk, $rose(arst_n) |-> (empty && !full), "queues not clear after reset")
endmodule

bind calibrated_compass_heading ccmp_checker u_ccmp_checker (.*);
`default_nettype wire

FILE: tb/sv/calibrated_compass_heading_tb.sv
// Testbench for the calibrated compass heading block: directed vectors, then random ones.
`timescale 1ns / 1ps
module calibrated_compass_heading_tb;

	localparam logic signed [15:0] NONE = 16'sh7fff;
	localparam int STEPS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic signed [15:0] mag_x = '0, mag_y = '0, mag_z = '0;
	logic full, empty;
	logic signed [15:0] heading;

	logic signed [15:0] pending_headings [$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic signed [15:0] want;
	} vec_row_t;

	calibrated_compass_heading dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.empty(empty), .pop(pop), .heading(heading)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint fshift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -((-(v + 1)) >>> s) - 1;
	endfunction

	function automatic logic signed [15:0] predict_heading(logic signed [15:0] rx,
			logic signed [15:0] ry, logic signed [15:0] rz);
		longint m1 [3][3] = '{'{31431, 2241, -6076}, '{2241, 38324, -1540},
			'{-6076, -1540, 32596}};
		longint o1 [3] = '{5566237, -1502416, 4814605};
		longint m2 [3][3] = '{'{1235086, -39397, 204957}, '{-39397, 1015048, -75652},
			'{204957, -75652, 1137231}};
		longint o2 [3] = '{28758, 11831, 8559};
		longint tab [24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
			5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};
		longint v [3], w [3], d [3];
		longint a, b, ang, ma, mb, da, db, acc;
		v[0] = longint'(rx) * 4096;
		v[1] = longint'(ry) * 4096;
		v[2] = longint'(rz) * 4096;
		for (int r = 0; r < 3; r++)
			d[r] = v[r] - o1[r];
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += m1[r][c] * d[c];
			w[r] = fshift(acc + (64'sd1 <<< 19), 20);
		end
		for (int r = 0; r < 3; r++)
			d[r] = w[r] - o2[r];
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += m2[r][c] * d[c];
			v[r] = fshift(acc + (64'sd1 <<< 19), 20);
		end
		a = v[1];
		b = v[0];
		ang = 0;
		if (a == 0 && b == 0)
			return 16'sd0;
		if (a < 0) begin
			ang = (b >= 0) ? 18000 * 256 : -18000 * 256;
			a = -a;
			b = -b;
		end
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		if (mb > ma)
			ma = mb;
		while (ma < (64'sd1 <<< 40)) begin
			a *= 2;
			b *= 2;
			ma *= 2;
		end
		for (int i = 0; i < (STEPS > 24 ? 24 : STEPS); i++) begin
			da = fshift(a, i);
			db = fshift(b, i);
			if (b > 0) begin
				a += db;
				b -= da;
				ang += tab[i];
			end else begin
				a -= db;
				b += da;
				ang -= tab[i];
			end
		end
		ang = fshift(ang + 128, 8);
		if (ang > 18000)
			ang = 18000;
		if (ang < -18000)
			ang = -18000;
		return 16'(ang);
	endfunction

	task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic signed [15:0] want);
		logic signed [15:0] p;
		p = predict_heading(x, y, z);
		if (want != NONE && want != p) begin
			$error("directed row: heading expected %0d, predicted %0d", want, p);
			errors++;
		end
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mag_x <= x;
		mag_y <= y;
		mag_z <= z;
		pending_headings.push_back(p);
		do
			@(posedge clk);
		while (full);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_headings.size() == 0) begin
				$error("heading %0d arrived with none expected", heading);
				errors++;
			end else begin
				if (heading !== pending_headings[0]) begin
					$error("heading: expected %0d, actual %0d", pending_headings[0], heading);
					errors++;
				end
				void'(pending_headings.pop_front());
			end
		end
		pop <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	initial begin
		#20000000;
		$display("** calibrated_compass_heading: FAILED **");
		$finish;
	end

	initial begin
		vec_row_t rows [$];
		int phase;
		rows = '{
			'{16'sh7fff, 16'sh7fff, 16'sh7fff, NONE},
			'{-16'sh8000, -16'sh8000, -16'sh8000, NONE},
			'{16'sh7fff, -16'sh8000, 16'sh0000, NONE},
			'{-16'sh8000, 16'sh7fff, 16'sh0000, NONE},
			'{16'sh0000, 16'sh0000, 16'sh0000, NONE},
			'{16'sh0000, 16'sh7fff, -16'sh8000, NONE},
			'{16'sh7fff, 16'sh0000, 16'sh7fff, NONE},
			'{-16'sh8000, 16'sh0000, -16'sh8000, NONE},
			'{16'sh0000, -16'sh8000, 16'sh7fff, NONE},
			'{16'sh5555, -16'sh2aab, 16'sh5555, NONE},
			'{-16'sh5556, 16'sh2aaa, -16'sh5556, NONE},
			'{16'sh0001, -16'sh0001, 16'sh0001, NONE},
			'{16'sh0555, -16'sh0172, 16'sh049a, NONE},
			'{16'sh0557, -16'sh016f, 16'sh0499, NONE},
			'{16'sh0554, -16'sh0170, 16'sh049b, NONE}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].want);
		for (int n = 0; n < 540; n++) begin
			phase = n / 90;
			send_idle = (phase == 1 || phase == 5) ? 81 : (phase == 3 ? 18 : 0);
			recv_stall = (phase == 2 || phase == 5) ? 81 : (phase == 3 ? 18 : 0);
			if ($urandom_range(3) == 0)
				send_vector(16'($urandom), 16'($urandom), 16'($urandom), NONE);
			else
				send_vector(16'sd1360 + 16'($signed($urandom_range(800)) - 400),
					-16'sd367 + 16'($signed($urandom_range(800)) - 400),
					16'sd1175 + 16'($signed($urandom_range(800)) - 400), NONE);
		end
		push <= 1'b0;
		recv_stall = 0;
		while (pending_headings.size() != 0)
			@(posedge clk);
		repeat (STEPS + 20) @(posedge clk);
		if (errors == 0)
			$display("** calibrated_compass_heading: PASSED **");
		else
			$display("** calibrated_compass_heading: FAILED **");
		$finish;
	end

endmodule
